### rtl/mpus_pkg.sv
package mpus_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HARD_TRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_TRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_WAIT  = 2'd2;

    localparam logic [3:0] HARD_TRIES_RST = 4'd3;
    localparam logic [3:0] SOFT_TRIES_RST = 4'd3;
    localparam logic [7:0] BOOT_WAIT_RST  = 8'd10;

    localparam logic [2:0] PHASE_IDLE = 3'd7;
    localparam logic [1:0] WAIT_STEP  = 2'd2;

    localparam logic [1:0] OUT_RUN  = 2'd0;
    localparam logic [1:0] OUT_UP   = 2'd1;
    localparam logic [1:0] OUT_FAIL = 2'd2;

    typedef struct packed {
        logic [3:0] hard_tries;
        logic [3:0] soft_tries;
        logic [7:0] boot_wait;
    } t_cfg;

    typedef struct packed {
        logic       supply_on;
        logic       supply_off;
        logic       switch_pulse;
        logic       send_probe;
        logic [1:0] wait_half_secs;
        logic [1:0] outcome;
        logic [2:0] phase_now;
    } t_result;

endpackage

### rtl/mpus_ifs.sv
interface mpus_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic probe_ok;

    modport source (output valid, output start_req, output probe_ok, input ready);
    modport sink (input valid, input start_req, input probe_ok, output ready);
endinterface

interface mpus_out_if;
    logic       valid;
    logic       ready;
    logic       supply_on;
    logic       supply_off;
    logic       switch_pulse;
    logic       send_probe;
    logic [1:0] wait_half_secs;
    logic [1:0] outcome;
    logic [2:0] phase_now;

    modport source (
        output valid, output supply_on, output supply_off, output switch_pulse,
        output send_probe, output wait_half_secs, output outcome, output phase_now,
        input ready
    );
    modport sink (
        input valid, input supply_on, input supply_off, input switch_pulse,
        input send_probe, input wait_half_secs, input outcome, input phase_now,
        output ready
    );
endinterface

### rtl/mpus_fsm.sv
module mpus_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_start,
    input  logic              i_ok,
    input  mpus_pkg::t_cfg    i_cfg,
    output mpus_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_POWER = 3'd1,
        PH_PULSE = 3'd2,
        PH_WAIT  = 3'd3,
        PH_CHECK = 3'd4,
        PH_SOFT  = 3'd5,
        PH_HARD  = 3'd6,
        PH_IDLE  = mpus_pkg::PHASE_IDLE
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_hard_left, n_hard_left;
    logic [3:0] r_soft_left, n_soft_left;
    logic [7:0] r_wait_left, n_wait_left;

    always_comb begin
        n_phase     = r_phase;
        n_hard_left = r_hard_left;
        n_soft_left = r_soft_left;
        n_wait_left = r_wait_left;
        o_res       = '0;
        if (i_start || r_phase == PH_INIT) begin
            n_hard_left = i_cfg.hard_tries;
            n_soft_left = i_cfg.soft_tries;
            n_phase     = PH_POWER;
        end else begin
            unique case (r_phase)
                PH_POWER: begin
                    o_res.supply_on      = 1'b1;
                    n_soft_left          = i_cfg.soft_tries;
                    if (r_hard_left != 4'd0) begin
                        n_hard_left = r_hard_left - 4'd1;
                    end
                    o_res.wait_half_secs = mpus_pkg::WAIT_STEP;
                    n_phase              = PH_PULSE;
                end
                PH_PULSE: begin
                    o_res.switch_pulse = 1'b1;
                    if (r_soft_left != 4'd0) begin
                        n_soft_left = r_soft_left - 4'd1;
                    end
                    n_wait_left = i_cfg.boot_wait;
                    n_phase     = PH_WAIT;
                end
                PH_WAIT: begin
                    o_res.wait_half_secs = mpus_pkg::WAIT_STEP;
                    if (r_wait_left != 8'd0) begin
                        n_wait_left = r_wait_left - 8'd1;
                    end else begin
                        o_res.send_probe = 1'b1;
                        n_phase          = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (i_ok) begin
                        o_res.outcome = mpus_pkg::OUT_UP;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_phase = PH_SOFT;
                    end
                end
                PH_SOFT: begin
                    n_phase = (r_soft_left != 4'd0) ? PH_PULSE : PH_HARD;
                end
                PH_HARD: begin
                    if (r_hard_left != 4'd0) begin
                        n_phase = PH_POWER;
                    end else begin
                        o_res.supply_off = 1'b1;
                        o_res.outcome    = mpus_pkg::OUT_FAIL;
                        n_phase          = PH_IDLE;
                    end
                end
                PH_INIT, PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        o_res.phase_now = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hard_left <= '0;
            r_soft_left <= '0;
            r_wait_left <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_hard_left <= n_hard_left;
            r_soft_left <= n_soft_left;
            r_wait_left <= n_wait_left;
        end
    end

endmodule

### rtl/mpus_out_reg.sv
module mpus_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mpus_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output mpus_pkg::t_result o_res
);

    logic              r_valid;
    mpus_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/modem_power_up_sequencer.sv
// channel    dir  handshake      payload
// i_item     in   valid/ready    start_req, probe_ok
// o_result   out  valid/ready    supply_on .. phase_now
// i_cfg_*    in   write enable   index 0..2, 8-bit data
//
// one item per cycle sustained while o_result is not stalled; a taken item passes
// through the input register, the step logic and the result register
// the phase and retry counters update when an item passes the step logic
// a stall at o_result holds the result register and then the input register
// synchronous active-low reset: phase idle, counters zero, config registers at defaults
module modem_power_up_sequencer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    mpus_in_if.sink                                i_item,
    mpus_out_if.source                             o_result,
    input  logic                                   i_cfg_we,
    input  logic [mpus_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [mpus_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    mpus_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic              r_start;
    logic              r_ok;
    logic              w_free;
    logic              w_adv;
    mpus_pkg::t_result w_step_res;
    mpus_pkg::t_result w_out_res;

    assign w_adv        = r_in_valid && w_free;
    assign i_item.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hard_tries <= mpus_pkg::HARD_TRIES_RST;
            r_cfg.soft_tries <= mpus_pkg::SOFT_TRIES_RST;
            r_cfg.boot_wait  <= mpus_pkg::BOOT_WAIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mpus_pkg::CFG_HARD_TRIES: r_cfg.hard_tries <= i_cfg_data[3:0];
                mpus_pkg::CFG_SOFT_TRIES: r_cfg.soft_tries <= i_cfg_data[3:0];
                mpus_pkg::CFG_BOOT_WAIT:  r_cfg.boot_wait  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_start <= i_item.start_req;
            r_ok    <= i_item.probe_ok;
        end
    end

    mpus_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_start (r_start),
        .i_ok    (r_ok),
        .i_cfg   (r_cfg),
        .o_res   (w_step_res)
    );

    mpus_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv),
        .i_res   (w_step_res),
        .i_ready (o_result.ready),
        .o_valid (o_result.valid),
        .o_free  (w_free),
        .o_res   (w_out_res)
    );

    assign o_result.supply_on      = w_out_res.supply_on;
    assign o_result.supply_off     = w_out_res.supply_off;
    assign o_result.switch_pulse   = w_out_res.switch_pulse;
    assign o_result.send_probe     = w_out_res.send_probe;
    assign o_result.wait_half_secs = w_out_res.wait_half_secs;
    assign o_result.outcome        = w_out_res.outcome;
    assign o_result.phase_now      = w_out_res.phase_now;

    // a buffered item is never dropped while the result side is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("buffered item lost");

    // at most one action per step
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> $countones({w_out_res.supply_on, w_out_res.supply_off,
            w_out_res.switch_pulse, w_out_res.send_probe}) <= 1)
        else $error("more than one action in a step");

    // a final outcome always returns the sequencer to idle
    a_outcome_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && w_out_res.outcome != mpus_pkg::OUT_RUN
            |-> w_out_res.phase_now == mpus_pkg::PHASE_IDLE)
        else $error("outcome reported without going idle");

    // supply off only comes with a failure outcome
    a_off_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && w_out_res.supply_off |-> w_out_res.outcome == mpus_pkg::OUT_FAIL)
        else $error("supply cut without failure");

endmodule

### tb/modem_power_up_sequencer_test.sv
`timescale 1ns / 100ps

module modem_power_up_sequencer_test;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int ITEMS_PER_SETTING = 84;
    localparam int NUM_SETTINGS = 6;
    localparam int IDX_W = mpus_pkg::CFG_IDX_W;
    localparam int DATA_W = mpus_pkg::CFG_DATA_W;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0] CFG_HARD = mpus_pkg::CFG_HARD_TRIES;
    localparam logic [IDX_W-1:0] CFG_SOFT = mpus_pkg::CFG_SOFT_TRIES;
    localparam logic [IDX_W-1:0] CFG_BOOT = mpus_pkg::CFG_BOOT_WAIT;
    localparam logic [1:0] W_STEP = mpus_pkg::WAIT_STEP;
    localparam logic [1:0] O_RUN = mpus_pkg::OUT_RUN;
    localparam logic [1:0] O_UP = mpus_pkg::OUT_UP;
    localparam logic [1:0] O_FAIL = mpus_pkg::OUT_FAIL;

    typedef enum logic [2:0] {
        PH_INIT, PH_POWER, PH_PULSE, PH_WAIT, PH_CHECK, PH_SOFT, PH_HARD, PH_IDLE
    } t_phase;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [IDX_W-1:0]       idx;
        logic [DATA_W-1:0]      data;
        logic                   start_req;
        logic                   probe_ok;
        logic                   typed;
        mpus_pkg::t_result      want;
    } t_seq_row;

    // want: supply_on, supply_off, switch_pulse, send_probe, wait, outcome, phase
    localparam t_seq_row SEQ_TABLE [32] = '{
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b1, '{0, 0, 0, 0, 0, O_RUN, PH_IDLE}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b1, 1'b0, 1'b1, '{0, 0, 0, 0, 0, O_RUN, PH_POWER}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b1, '{1, 0, 0, 0, W_STEP, O_RUN, PH_PULSE}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b1, 1'b1, 1'b1, '{0, 0, 0, 0, 0, O_RUN, PH_POWER}},
        '{ROW_CFG, CFG_HARD, 8'hf1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_SOFT, 8'he1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_BOOT, 8'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_UNUSED, 8'hff, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b1, 1'b0, 1'b1, '{0, 0, 0, 0, 0, O_RUN, PH_POWER}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b1, '{1, 0, 0, 0, W_STEP, O_RUN, PH_PULSE}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b1, '{0, 0, 1, 0, 0, O_RUN, PH_WAIT}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b1, '{0, 0, 0, 1, W_STEP, O_RUN, PH_CHECK}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b1, '{0, 0, 0, 0, 0, O_RUN, PH_SOFT}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b1, '{0, 1, 0, 0, 0, O_FAIL, PH_IDLE}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b1, '{0, 0, 0, 0, 0, O_UP, PH_IDLE}},
        '{ROW_CFG, CFG_HARD, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_SOFT, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_BOOT, 8'd1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b0, 1'b0, 1'b1, '{0, 1, 0, 0, 0, O_FAIL, PH_IDLE}},
        '{ROW_ITEM, 2'd0, 8'd0, 1'b1, 1'b1, 1'b0, '0}
    };

    localparam logic [3:0] SET_HARD [NUM_SETTINGS] = '{4'd3, 4'd15, 4'd0, 4'd15, 4'd0, 4'd2};
    localparam logic [3:0] SET_SOFT [NUM_SETTINGS] = '{4'd3, 4'd15, 4'd0, 4'd0, 4'd15, 4'd1};
    localparam logic [7:0] SET_BOOT [NUM_SETTINGS] = '{8'd10, 8'd255, 8'd0, 8'd2, 8'd1, 8'd3};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [IDX_W-1:0]       cfg_idx;
    logic [DATA_W-1:0]      cfg_data;

    mpus_in_if  in_ch ();
    mpus_out_if out_ch ();

    modem_power_up_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // sequencer state and registers as seen by the predictor
    logic [3:0] reg_hard = mpus_pkg::HARD_TRIES_RST;
    logic [3:0] reg_soft = mpus_pkg::SOFT_TRIES_RST;
    logic [7:0] reg_boot = mpus_pkg::BOOT_WAIT_RST;
    t_phase     seq_phase = PH_IDLE;
    logic [3:0] hard_left = '0;
    logic [3:0] soft_left = '0;
    logic [7:0] wait_left = '0;

    mpus_pkg::t_result pending_results [$];
    int         errors = 0;
    bit         gaps_on = 1'b1;
    int         idle_cycles = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic mpus_pkg::t_result power_up_step(logic start_req, logic probe_ok);
        mpus_pkg::t_result r;
        r = '0;
        if (start_req || seq_phase == PH_INIT) begin
            hard_left = reg_hard;
            soft_left = reg_soft;
            seq_phase = PH_POWER;
        end else begin
            case (seq_phase)
                PH_POWER: begin
                    r.supply_on = 1'b1;
                    soft_left = reg_soft;
                    if (hard_left != 0)
                        hard_left = hard_left - 1'b1;
                    r.wait_half_secs = W_STEP;
                    seq_phase = PH_PULSE;
                end
                PH_PULSE: begin
                    r.switch_pulse = 1'b1;
                    if (soft_left != 0)
                        soft_left = soft_left - 1'b1;
                    wait_left = reg_boot;
                    seq_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    r.wait_half_secs = W_STEP;
                    if (wait_left != 0) begin
                        wait_left = wait_left - 1'b1;
                    end else begin
                        r.send_probe = 1'b1;
                        seq_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (probe_ok) begin
                        r.outcome = O_UP;
                        seq_phase = PH_IDLE;
                    end else begin
                        seq_phase = PH_SOFT;
                    end
                end
                PH_SOFT: begin
                    seq_phase = (soft_left != 0) ? PH_PULSE : PH_HARD;
                end
                PH_HARD: begin
                    if (hard_left != 0) begin
                        seq_phase = PH_POWER;
                    end else begin
                        r.supply_off = 1'b1;
                        r.outcome = O_FAIL;
                        seq_phase = PH_IDLE;
                    end
                end
                default: seq_phase = PH_IDLE;
            endcase
        end
        r.phase_now = seq_phase;
        return r;
    endfunction

    task automatic send_item(logic start_req, logic probe_ok, logic typed,
                             mpus_pkg::t_result want);
        mpus_pkg::t_result predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.start_req <= start_req;
        in_ch.probe_ok <= probe_ok;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = power_up_step(start_req, probe_ok);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HARD: reg_hard = data[3:0];
            CFG_SOFT: reg_soft = data[3:0];
            CFG_BOOT: reg_boot = data;
            default: ;
        endcase
    endtask

    task automatic cmp_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // result side: random back-pressure
    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                stall = gap_len() - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        mpus_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual phase_now %0d",
                    $time, out_ch.phase_now);
            end else begin
                want = pending_results.pop_front();
                cmp_field("supply_on", want.supply_on, out_ch.supply_on);
                cmp_field("supply_off", want.supply_off, out_ch.supply_off);
                cmp_field("switch_pulse", want.switch_pulse, out_ch.switch_pulse);
                cmp_field("send_probe", want.send_probe, out_ch.send_probe);
                cmp_field("wait_half_secs", want.wait_half_secs, out_ch.wait_half_secs);
                cmp_field("outcome", want.outcome, out_ch.outcome);
                cmp_field("phase_now", want.phase_now, out_ch.phase_now);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic start_req;
        logic probe_ok;
        in_ch.valid = 1'b0;
        in_ch.start_req = 1'b0;
        in_ch.probe_ok = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sequences
        foreach (SEQ_TABLE[i]) begin
            if (SEQ_TABLE[i].kind == ROW_CFG)
                write_reg(SEQ_TABLE[i].idx, SEQ_TABLE[i].data);
            else
                send_item(SEQ_TABLE[i].start_req, SEQ_TABLE[i].probe_ok,
                    SEQ_TABLE[i].typed, SEQ_TABLE[i].want);
        end

        // random sequences under several settings
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            write_reg(CFG_HARD, {4'($urandom), SET_HARD[s]});
            write_reg(CFG_SOFT, {4'($urandom), SET_SOFT[s]});
            write_reg(CFG_BOOT, SET_BOOT[s]);
            gaps_on = (s != 1);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (seq_phase == PH_IDLE)
                    start_req = ($urandom_range(0, 7) != 0);
                else
                    start_req = ($urandom_range(0, 39) == 0);
                if (seq_phase == PH_CHECK)
                    probe_ok = ($urandom_range(0, 2) == 0);
                else
                    probe_ok = 1'($urandom_range(0, 1));
                send_item(start_req, probe_ok, 1'b0, '0);
            end
        end
        gaps_on = 1'b1;

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
